// ----- sv/bpfa_pkg.sv -----
`timescale 1ns / 1ps

package bpfa_pkg;

   typedef enum logic [1:0] {
      OP_ALLOC_PAGE  = 2'd0,
      OP_FREE_PAGE   = 2'd1,
      OP_RESERVE_RNG = 2'd2,
      OP_FREE_RNG    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_CHECK
   } state_type;

   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned ADDR_OUT_BITS = 27;

endpackage

// ----- sv/bitmap_page_frame_allocator.sv -----
`timescale 1ns / 1ps
// sequence: allocate reads then checks each bitmap word scanned, free and range ops read then
// write each word touched, and the result strobe is registered; trivial requests answer in
// the cycle after start. one request at a time: busy stays high until the result is out.
// after reset the bitmap is filled with ones, one word per cycle (MAP_WORDS words, 1024
// at the defaults) while busy is high; csr writes are taken in any state out of reset.
// the result strobe lasts one cycle and the receiver cannot stall it.
module bitmap_page_frame_allocator
   import bpfa_pkg::*;
#(
   parameter int unsigned NUM_PAGES  = 32768,
   parameter int unsigned PAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_address,
   input  logic [31:0] req_length,
   output logic        rsp_strobe,
   output logic [26:0] rsp_page_address,
   output logic        rsp_out_of_memory,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   localparam int unsigned MAP_WORDS = (NUM_PAGES + 31) / 32;
   localparam int unsigned WAW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int unsigned PIW = WAW + 5;
   localparam int unsigned PB_SHIFT = $clog2(PAGE_BYTES);

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [WAW-1:0]       mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;

   state_type      state_ff, state_in;
   logic [WAW-1:0] word_ff, word_in;
   logic [WAW-1:0] first_word_ff, first_word_in;
   logic [WAW-1:0] last_word_ff, last_word_in;
   logic [4:0]     first_bit_ff, first_bit_in;
   logic [4:0]     last_bit_ff, last_bit_in;
   logic           alloc_ff, alloc_in;
   logic           set_ff, set_in;
   logic [15:0]    managed_ff;

   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [ADDR_OUT_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic                     rsp_oom_ff, rsp_oom_in;

   // request decode
   op_type      req_op;
   logic [31:0] first_page;
   logic [31:0] page_count;
   logic [32:0] end_raw;
   logic [32:0] end_clip;
   logic [32:0] alloc_limit;
   logic [32:0] last_range;
   logic [32:0] last_alloc;

   // word processing
   logic [4:0]           lo_bit;
   logic [4:0]           hi_bit;
   logic [WORD_BITS-1:0] word_mask;
   logic [WORD_BITS-1:0] avail;
   logic [4:0]           pick_bit;
   logic [PIW-1:0]       pick_page;
   logic [63:0]          pick_bytes;

   always_comb begin
      req_op      = op_type'(req_operation);
      first_page  = req_address >> PB_SHIFT;
      page_count  = (req_op == OP_FREE_PAGE) ? 32'd1 : (req_length >> PB_SHIFT);
      end_raw     = {1'b0, first_page} + {1'b0, page_count};
      end_clip    = (end_raw > 33'(NUM_PAGES)) ? 33'(NUM_PAGES) : end_raw;
      alloc_limit = ({17'd0, managed_ff} > 33'(NUM_PAGES)) ? 33'(NUM_PAGES)
                                                           : {17'd0, managed_ff};
      last_range  = end_clip - 33'd1;
      last_alloc  = alloc_limit - 33'd1;
   end

   always_comb begin
      lo_bit    = (word_ff == first_word_ff) ? first_bit_ff : 5'd0;
      hi_bit    = (word_ff == last_word_ff) ? last_bit_ff : 5'd31;
      word_mask = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (5'd31 - hi_bit));
      avail     = ~rd_data_ff & word_mask;
      pick_bit  = 5'd0;
      // lowest free bit wins
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            pick_bit = 5'(i);
         end
      end
      pick_page  = {word_ff, pick_bit};
      pick_bytes = 64'(pick_page) << PB_SHIFT;
   end

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      first_word_in = first_word_ff;
      last_word_in  = last_word_ff;
      first_bit_in  = first_bit_ff;
      last_bit_in   = last_bit_ff;
      alloc_in      = alloc_ff;
      set_in        = set_ff;
      rsp_strobe_in = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_oom_in    = rsp_oom_ff;
      mem_we        = 1'b0;
      mem_waddr     = word_ff;
      mem_wdata     = {WORD_BITS{1'b1}};
      unique case (state_ff)
         ST_INIT: begin
            mem_we  = 1'b1;
            word_in = WAW'(word_ff + 1'b1);
            if (word_ff == WAW'(MAP_WORDS - 1)) begin
               word_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               rsp_addr_in = '0;
               rsp_oom_in  = 1'b0;
               set_in      = (req_op == OP_RESERVE_RNG);
               if (req_op == OP_ALLOC_PAGE) begin
                  alloc_in      = 1'b1;
                  word_in       = '0;
                  first_word_in = '0;
                  first_bit_in  = 5'd0;
                  last_word_in  = last_alloc[PIW-1:5];
                  last_bit_in   = last_alloc[4:0];
                  if (alloc_limit == 33'd0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_oom_in    = 1'b1;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  alloc_in      = 1'b0;
                  word_in       = first_page[PIW-1:5];
                  first_word_in = first_page[PIW-1:5];
                  first_bit_in  = first_page[4:0];
                  last_word_in  = last_range[PIW-1:5];
                  last_bit_in   = last_range[4:0];
                  // empty range, or start past the end of the store
                  if ({1'b0, first_page} >= end_clip) begin
                     rsp_strobe_in = 1'b1;
                  end else begin
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (alloc_ff) begin
               if (avail != '0) begin
                  mem_we        = 1'b1;
                  mem_wdata     = rd_data_ff | (32'd1 << pick_bit);
                  rsp_strobe_in = 1'b1;
                  rsp_addr_in   = pick_bytes[ADDR_OUT_BITS-1:0];
                  state_in      = ST_IDLE;
               end else if (word_ff == last_word_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_oom_in    = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  word_in  = WAW'(word_ff + 1'b1);
                  state_in = ST_READ;
               end
            end else begin
               mem_we    = 1'b1;
               mem_wdata = set_ff ? (rd_data_ff | word_mask) : (rd_data_ff & ~word_mask);
               if (word_ff == last_word_ff) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  word_in  = WAW'(word_ff + 1'b1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         word_ff       <= '0;
         managed_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_ff       <= word_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            managed_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_word_ff <= first_word_in;
      last_word_ff  <= last_word_in;
      first_bit_ff  <= first_bit_in;
      last_bit_ff   <= last_bit_in;
      alloc_ff      <= alloc_in;
      set_ff        <= set_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_oom_ff    <= rsp_oom_in;
   end

   // bitmap store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[word_ff];
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_page_address  = rsp_addr_ff;
   assign rsp_out_of_memory = rsp_oom_ff;

endmodule
